// ===== rtl/mtla_pkg.sv =====
// ----------------------------------------------------------------------------
// mtla_pkg
// Shared constants, types and divider reciprocals for the two-stage
// moving-average / limit-average filter.
// ----------------------------------------------------------------------------
package mtla_pkg;

	localparam int CHANNELS = 8;
	localparam int MA_DEPTH = 10;
	localparam int LA_DEPTH = 5;

	localparam int CH_W     = 3;
	localparam int SAMPLE_W = 12;
	localparam int LIMIT_W  = 12;
	localparam logic [LIMIT_W-1:0] SPIKE_LIMIT_RST = 12'd50;

	localparam int CH_SLOTS  = 1 << CH_W;
	localparam int SAMPLE_MAX = (1 << SAMPLE_W) - 1;

	// Moving-average window memory: one row of 2**MA_PTR_W entries per channel.
	localparam int MA_PTR_W  = $clog2(MA_DEPTH);
	localparam int MA_ADDR_W = CH_W + MA_PTR_W;
	localparam int MA_SLOTS  = 1 << MA_ADDR_W;
	localparam int MA_SUM_W  = 16;

	// Limit-average window memory, organised the same way.
	localparam int LA_PTR_W  = $clog2(LA_DEPTH);
	localparam int LA_ADDR_W = CH_W + LA_PTR_W;
	localparam int LA_SLOTS  = 1 << LA_ADDR_W;
	localparam int LA_SUM_W  = 15;

	// Exact floor division by a constant: floor(x / d) = (x * m) >> sh for all
	// x below 2**n, with sh = n + ceil(log2 d) and m = ceil(2**sh / d).
	localparam int MA_SH    = MA_SUM_W + $clog2(MA_DEPTH);
	localparam int MA_RCP_W = MA_SUM_W + 1;
	localparam int MA_PRD_W = MA_SUM_W + MA_RCP_W;
	localparam logic [MA_RCP_W-1:0] MA_RCP =
		MA_RCP_W'(((64'd1 << MA_SH) + 64'(MA_DEPTH) - 64'd1) / 64'(MA_DEPTH));

	localparam int LA_SH    = LA_SUM_W + $clog2(LA_DEPTH);
	localparam int LA_RCP_W = LA_SUM_W + 1;
	localparam int LA_PRD_W = LA_SUM_W + LA_RCP_W;
	localparam logic [LA_RCP_W-1:0] LA_RCP =
		LA_RCP_W'(((64'd1 << LA_SH) + 64'(LA_DEPTH) - 64'd1) / 64'(LA_DEPTH));

	// Output queue; its depth covers the pipeline latency at full rate.
	localparam int OFIFO_DEPTH = 8;
	localparam int OFIFO_PTR_W = $clog2(OFIFO_DEPTH);
	localparam int OFIFO_CNT_W = $clog2(OFIFO_DEPTH + 1);

	typedef logic [CH_W-1:0]     ch_t;
	typedef logic [SAMPLE_W-1:0] sample_t;

	typedef struct packed {
		logic    valid;
		ch_t     ch;
		sample_t sample;
	} in_item_t;

	typedef struct packed {
		logic               we;
		logic [LIMIT_W-1:0] value;
	} cfg_wr_t;

	typedef struct packed {
		logic    valid;
		logic    live;
		ch_t     ch;
		sample_t value;
	} ma_item_t;

	typedef struct packed {
		logic    valid;
		ch_t     ch;
		sample_t value;
	} res_item_t;

endpackage

// ===== rtl/mtla_if.sv =====
// ----------------------------------------------------------------------------
// mtla channel interfaces
// Valid/ready channels for samples in, filtered results out and the
// spike-limit register write.
// ----------------------------------------------------------------------------
interface mtla_in_if;
	logic                            valid;
	logic                            ready;
	logic [mtla_pkg::CH_W-1:0]       channel;
	logic [mtla_pkg::SAMPLE_W-1:0]   sample;

	modport source (output valid, output channel, output sample, input ready);
	modport sink (input valid, input channel, input sample, output ready);
endinterface

interface mtla_out_if;
	logic                            valid;
	logic                            ready;
	logic [mtla_pkg::CH_W-1:0]       channel_out;
	logic [mtla_pkg::SAMPLE_W-1:0]   filtered;

	modport source (output valid, output channel_out, output filtered, input ready);
	modport sink (input valid, input channel_out, input filtered, output ready);
endinterface

interface mtla_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [mtla_pkg::LIMIT_W-1:0]    spike_limit;

	modport source (output valid, output spike_limit, input ready);
	modport sink (input valid, input spike_limit, output ready);
endinterface

// ===== rtl/mtla_ma_stage.sv =====
// ----------------------------------------------------------------------------
// mtla_ma_stage
// Per-channel moving average: window ring in a synchronous memory, running
// sums in registers, division by the window length through a reciprocal.
// ----------------------------------------------------------------------------
module mtla_ma_stage (
	input  logic               clk,
	input  logic               arst_n,
	input  mtla_pkg::in_item_t in_item,
	output mtla_pkg::ma_item_t ma_item
);
	import mtla_pkg::*;

	sample_t                ma_mem [MA_SLOTS];
	logic [MA_PTR_W-1:0]    ptr_q [CH_SLOTS];
	logic [CH_SLOTS-1:0]    full_q;
	logic [MA_SUM_W-1:0]    sum_q [CH_SLOTS];

	logic                   live;
	logic [MA_PTR_W-1:0]    ptr_rd;
	logic [MA_ADDR_W-1:0]   addr;

	logic                   valid_s1, live_s1, full_s1;
	ch_t                    ch_s1;
	sample_t                sample_s1, old_s1;
	logic [MA_SUM_W-1:0]    sum_nxt;

	logic                   valid_s2, live_s2, full_s2;
	ch_t                    ch_s2;
	sample_t                sample_s2;
	logic [MA_SUM_W-1:0]    sum_s2;

	logic                   valid_s3, live_s3, full_s3;
	ch_t                    ch_s3;
	sample_t                sample_s3;
	logic [MA_PRD_W-1:0]    prod_s3;

	assign live   = in_item.valid && (int'(in_item.ch) < CHANNELS);
	assign ptr_rd = ptr_q[in_item.ch];
	assign addr   = {in_item.ch, ptr_rd};

	// The oldest entry is read and the new sample written at the same address
	// on the same edge, so the read returns the value being replaced.
	always_ff @(posedge clk) begin
		if (in_item.valid) begin
			old_s1 <= ma_mem[addr];
		end
		if (live) begin
			ma_mem[addr] <= in_item.sample;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CH_SLOTS; i++) begin
				ptr_q[i] <= '0;
			end
			full_q <= '0;
		end else if (live) begin
			if (ptr_rd == MA_PTR_W'(MA_DEPTH - 1)) begin
				ptr_q[in_item.ch]  <= '0;
				full_q[in_item.ch] <= 1'b1;
			end else begin
				ptr_q[in_item.ch] <= ptr_rd + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			live_s1  <= 1'b0;
			valid_s2 <= 1'b0;
			live_s2  <= 1'b0;
			valid_s3 <= 1'b0;
			live_s3  <= 1'b0;
		end else begin
			valid_s1 <= in_item.valid;
			live_s1  <= live;
			valid_s2 <= valid_s1;
			live_s2  <= live_s1;
			valid_s3 <= valid_s2;
			live_s3  <= live_s2;
		end
	end

	always_ff @(posedge clk) begin
		ch_s1     <= in_item.ch;
		sample_s1 <= in_item.sample;
		full_s1   <= full_q[in_item.ch];
		ch_s2     <= ch_s1;
		sample_s2 <= sample_s1;
		full_s2   <= full_s1;
		sum_s2    <= sum_nxt;
		ch_s3     <= ch_s2;
		sample_s3 <= sample_s2;
		full_s3   <= full_s2;
		prod_s3   <= MA_PRD_W'(sum_s2) * MA_PRD_W'(MA_RCP);
	end

	assign sum_nxt = sum_q[ch_s1] - (full_s1 ? MA_SUM_W'(old_s1) : '0)
		+ MA_SUM_W'(sample_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CH_SLOTS; i++) begin
				sum_q[i] <= '0;
			end
		end else if (live_s1) begin
			sum_q[ch_s1] <= sum_nxt;
		end
	end

	// While the window is still filling the raw sample passes straight through.
	assign ma_item.valid = valid_s3;
	assign ma_item.live  = live_s3;
	assign ma_item.ch    = ch_s3;
	assign ma_item.value = (live_s3 && full_s3) ? prod_s3[MA_SH +: SAMPLE_W] : sample_s3;

	a_ptr_range: assert property (@(posedge clk) disable iff (!arst_n)
		live |-> int'(ptr_rd) < MA_DEPTH)
		else $error("moving-average pointer beyond window");

	a_sum_bound: assert property (@(posedge clk) disable iff (!arst_n)
		live_s1 |-> int'(sum_nxt) <= MA_DEPTH * SAMPLE_MAX)
		else $error("moving-average sum out of range");

endmodule

// ===== rtl/mtla_la_stage.sv =====
// ----------------------------------------------------------------------------
// mtla_la_stage
// Per-channel limit average with spike rejection. Window ring in a two-read
// synchronous memory, running sums and newest values in registers.
// ----------------------------------------------------------------------------
module mtla_la_stage (
	input  logic                clk,
	input  logic                arst_n,
	input  mtla_pkg::ma_item_t  ma_item,
	input  mtla_pkg::cfg_wr_t   cfg_wr,
	output mtla_pkg::res_item_t la_item
);
	import mtla_pkg::*;

	sample_t                la_mem [LA_SLOTS];
	logic [LA_PTR_W-1:0]    head_q [CH_SLOTS];
	logic [CH_SLOTS-1:0]    wrap_q;
	logic [CH_SLOTS-1:0]    started_q;
	sample_t                init_q [CH_SLOTS];
	sample_t                newest_q [CH_SLOTS];
	logic [LA_SUM_W-1:0]    sum_q [CH_SLOTS];
	logic [LIMIT_W-1:0]     limit_q;

	logic [LA_PTR_W-1:0]    head_rd, head_inc;
	logic                   fwd;

	logic                   valid_s1, live_s1, fwd_s1, wrap_s1;
	ch_t                    ch_s1;
	sample_t                val_s1, rd_a_s1, rd_b_s1;
	logic [LA_PTR_W-1:0]    head_s1, head_s1_inc;

	sample_t                newest, oldest, diff;
	logic                   started, spike, start, commit;
	logic [LA_SUM_W-1:0]    sum_acc;

	logic                   valid_s2, div_s2;
	ch_t                    ch_s2;
	sample_t                pass_s2;
	logic [LA_SUM_W-1:0]    sum_s2;

	logic                   valid_s3, div_s3;
	ch_t                    ch_s3;
	sample_t                pass_s3;
	logic [LA_PRD_W-1:0]    prod_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= SPIKE_LIMIT_RST;
		end else if (cfg_wr.we) begin
			limit_q <= cfg_wr.value;
		end
	end

	// The item ahead may move this channel's head in the same edge as these
	// reads, so both the current and the following entry are fetched.
	assign head_rd  = head_q[ma_item.ch];
	assign head_inc = (head_rd == LA_PTR_W'(LA_DEPTH - 1)) ? '0 : head_rd + 1'b1;
	assign fwd      = commit && (ch_s1 == ma_item.ch);

	always_ff @(posedge clk) begin
		if (ma_item.valid) begin
			rd_a_s1 <= la_mem[{ma_item.ch, head_rd}];
			rd_b_s1 <= la_mem[{ma_item.ch, head_inc}];
		end
		if (commit) begin
			la_mem[{ch_s1, head_s1}] <= val_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			live_s1  <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s1 <= ma_item.valid;
			live_s1  <= ma_item.valid && ma_item.live;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		ch_s1   <= ma_item.ch;
		val_s1  <= ma_item.value;
		fwd_s1  <= fwd;
		head_s1 <= fwd ? head_inc : head_rd;
		wrap_s1 <= wrap_q[ma_item.ch]
			|| (fwd && head_rd == LA_PTR_W'(LA_DEPTH - 1));
	end

	// Entries not yet rewritten since the channel started still hold its
	// first value, which is kept in a register instead of being swept in.
	always_comb begin
		started = started_q[ch_s1];
		newest  = newest_q[ch_s1];
		oldest  = wrap_s1 ? (fwd_s1 ? rd_b_s1 : rd_a_s1) : init_q[ch_s1];
		diff    = (val_s1 >= newest) ? val_s1 - newest : newest - val_s1;
		spike   = diff > limit_q;
		start   = live_s1 && !started;
		commit  = live_s1 && started && !spike;
		sum_acc = sum_q[ch_s1] - LA_SUM_W'(oldest) + LA_SUM_W'(val_s1);
	end

	assign head_s1_inc = (head_s1 == LA_PTR_W'(LA_DEPTH - 1)) ? '0 : head_s1 + 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CH_SLOTS; i++) begin
				head_q[i] <= '0;
			end
			wrap_q    <= '0;
			started_q <= '0;
		end else if (start) begin
			started_q[ch_s1] <= 1'b1;
		end else if (commit) begin
			head_q[ch_s1] <= head_s1_inc;
			wrap_q[ch_s1] <= wrap_s1 || (head_s1 == LA_PTR_W'(LA_DEPTH - 1));
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			init_q[ch_s1]   <= val_s1;
			newest_q[ch_s1] <= val_s1;
			sum_q[ch_s1]    <= LA_SUM_W'(int'(val_s1) * LA_DEPTH);
		end else if (commit) begin
			newest_q[ch_s1] <= val_s1;
			sum_q[ch_s1]    <= sum_acc;
		end
	end

	always_ff @(posedge clk) begin
		ch_s2   <= ch_s1;
		div_s2  <= commit;
		pass_s2 <= (live_s1 && started) ? newest : val_s1;
		sum_s2  <= sum_acc;
		ch_s3   <= ch_s2;
		div_s3  <= div_s2;
		pass_s3 <= pass_s2;
		prod_s3 <= LA_PRD_W'(sum_s2) * LA_PRD_W'(LA_RCP);
	end

	assign la_item.valid = valid_s3;
	assign la_item.ch    = ch_s3;
	assign la_item.value = div_s3 ? prod_s3[LA_SH +: SAMPLE_W] : pass_s3;

	a_fresh_channel: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> head_s1 == '0 && !wrap_s1)
		else $error("limit-average channel not clean at its first value");

	a_fwd_follows: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && fwd_s1 |-> $past(valid_s1) && ch_s1 == $past(ch_s1))
		else $error("head forwarded without a same-channel predecessor");

	a_sum_bound: assert property (@(posedge clk) disable iff (!arst_n)
		commit |-> int'(sum_acc) <= LA_DEPTH * SAMPLE_MAX)
		else $error("limit-average sum out of range");

endmodule

// ===== rtl/mtla_out_fifo.sv =====
// ----------------------------------------------------------------------------
// mtla_out_fifo
// Output queue for filtered results with a credit count that throttles
// input transactions so that no result is ever dropped.
// ----------------------------------------------------------------------------
module mtla_out_fifo (
	input  logic                clk,
	input  logic                arst_n,
	input  mtla_pkg::res_item_t la_item,
	input  logic                in_accept,
	output logic                credit_ok,
	mtla_out_if.source          results
);
	import mtla_pkg::*;

	res_item_t              fifo_mem [OFIFO_DEPTH];
	logic [OFIFO_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [OFIFO_CNT_W-1:0] fill_q, credit_q;
	logic                   push, pop;

	assign push = la_item.valid;
	assign pop  = results.valid && results.ready;

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_mem[wr_ptr_q] <= la_item;
		end
	end

	// Credits count every transaction taken in and not yet delivered, so
	// items still inside the pipeline already own a queue slot.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
			credit_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			fill_q   <= fill_q + OFIFO_CNT_W'(push) - OFIFO_CNT_W'(pop);
			credit_q <= credit_q + OFIFO_CNT_W'(in_accept) - OFIFO_CNT_W'(pop);
		end
	end

	assign credit_ok           = credit_q < OFIFO_CNT_W'(OFIFO_DEPTH);
	assign results.valid       = fill_q != '0;
	assign results.channel_out = fifo_mem[rd_ptr_q].ch;
	assign results.filtered    = fifo_mem[rd_ptr_q].value;

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> fill_q < OFIFO_CNT_W'(OFIFO_DEPTH))
		else $error("output queue overflow");

	a_credit_cover: assert property (@(posedge clk) disable iff (!arst_n)
		credit_q >= fill_q && credit_q <= OFIFO_CNT_W'(OFIFO_DEPTH))
		else $error("credit count inconsistent with queue fill");

endmodule

// ===== rtl/moving_then_limit_average_filter_unit.sv =====
// ----------------------------------------------------------------------------
// moving_then_limit_average_filter_unit
// Two-stage per-channel smoothing of interleaved 12-bit converter samples.
// ----------------------------------------------------------------------------
// One sample of any channel can be taken in every clock cycle while
// samples.ready is high, also when consecutive samples belong to the same
// channel, and each gives exactly one result in arrival order. The pipeline
// is a moving-average section (window memory read and write, sum update,
// reciprocal multiply) followed by a limit-average section (window memory
// read, spike test and sum update, reciprocal multiply). Results wait in an
// eight-entry output queue, and samples.ready falls while eight transactions
// are taken and not yet delivered, so a stalled result consumer throttles the
// input after eight samples. The spike limit resets to 50 and is written
// through cfg, which is always ready; write it only while no sample is in
// flight. The block needs no initialisation pass after reset.
// ----------------------------------------------------------------------------
module moving_then_limit_average_filter_unit (
	input  logic       clk,
	input  logic       arst_n,
	mtla_in_if.sink    samples,
	mtla_cfg_if.sink   cfg,
	mtla_out_if.source results
);
	import mtla_pkg::*;

	in_item_t  in_item;
	cfg_wr_t   cfg_wr;
	ma_item_t  ma_item;
	res_item_t la_item;
	logic      credit_ok;

	assign samples.ready  = credit_ok;
	assign in_item.valid  = samples.valid && credit_ok;
	assign in_item.ch     = samples.channel;
	assign in_item.sample = samples.sample;

	assign cfg.ready    = 1'b1;
	assign cfg_wr.we    = cfg.valid;
	assign cfg_wr.value = cfg.spike_limit;

	mtla_ma_stage u_ma (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_item (in_item),
		.ma_item (ma_item)
	);

	mtla_la_stage u_la (
		.clk     (clk),
		.arst_n  (arst_n),
		.ma_item (ma_item),
		.cfg_wr  (cfg_wr),
		.la_item (la_item)
	);

	mtla_out_fifo u_ofifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.la_item   (la_item),
		.in_accept (in_item.valid),
		.credit_ok (credit_ok),
		.results   (results)
	);

endmodule

// ===== dv/tb_moving_then_limit_average_filter_unit.sv =====
// ----------------------------------------------------------------------------
// tb_moving_then_limit_average_filter_unit
// Self-checking bench for the two-stage per-channel smoothing filter. Samples
// are driven on the input channel with random gaps while the result side
// stalls at random. A scoreboard class keeps its own per-channel window state,
// predicts each filtered value as a sample is taken, and compares every
// delivered result in order. The spike limit is rewritten between phases,
// each time once the block has drained.
// ----------------------------------------------------------------------------
import mtla_pkg::*;

class filter_scoreboard;
	typedef struct {
		ch_t     ch;
		sample_t value;
	} filtered_t;

	sample_t             ma_win [CHANNELS][MA_DEPTH];
	bit [MA_SUM_W-1:0]   ma_acc [CHANNELS];
	int                  ma_count [CHANNELS];
	int                  ma_oldest [CHANNELS];
	sample_t             la_win [CHANNELS][LA_DEPTH];
	bit [LA_SUM_W-1:0]   la_acc [CHANNELS];
	int                  la_oldest [CHANNELS];
	bit                  la_primed [CHANNELS];
	logic [LIMIT_W-1:0]  spike_limit;
	filtered_t           filtered_due [$];
	int                  errors;

	function new();
		for (int c = 0; c < CHANNELS; c++) begin
			ma_acc[c]    = '0;
			ma_count[c]  = 0;
			ma_oldest[c] = 0;
			la_acc[c]    = '0;
			la_oldest[c] = 0;
			la_primed[c] = 1'b0;
		end
		spike_limit = SPIKE_LIMIT_RST;
		errors      = 0;
	endfunction

	function sample_t moving_avg(int ch, sample_t v);
		int h;
		// While the window fills, the raw sample passes straight through.
		if (ma_count[ch] < MA_DEPTH) begin
			ma_win[ch][ma_count[ch]] = v;
			ma_acc[ch] = ma_acc[ch] + v;
			ma_count[ch]++;
			ma_oldest[ch] = 0;
			return v;
		end
		h = ma_oldest[ch];
		ma_acc[ch] = ma_acc[ch] - ma_win[ch][h] + v;
		ma_win[ch][h] = v;
		ma_oldest[ch] = (h + 1) % MA_DEPTH;
		return sample_t'(ma_acc[ch] / MA_DEPTH);
	endfunction

	function sample_t limit_avg(int ch, sample_t v);
		int      h;
		int      diff;
		sample_t newest;
		if (!la_primed[ch]) begin
			la_acc[ch] = '0;
			for (int i = 0; i < LA_DEPTH; i++) begin
				la_win[ch][i] = v;
				la_acc[ch] = la_acc[ch] + v;
			end
			la_oldest[ch] = 0;
			la_primed[ch] = 1'b1;
			return v;
		end
		h = la_oldest[ch];
		newest = la_win[ch][(h + LA_DEPTH - 1) % LA_DEPTH];
		diff = (v > newest) ? int'(v) - int'(newest) : int'(newest) - int'(v);
		// A jump of exactly the limit is still accepted.
		if (diff > int'(spike_limit))
			return newest;
		la_acc[ch] = la_acc[ch] - la_win[ch][h] + v;
		la_win[ch][h] = v;
		la_oldest[ch] = (h + 1) % LA_DEPTH;
		return sample_t'(la_acc[ch] / LA_DEPTH);
	endfunction

	function void note_sample(ch_t ch, sample_t s);
		filtered_t e;
		e.ch = ch;
		if (int'(ch) < CHANNELS)
			e.value = limit_avg(int'(ch), moving_avg(int'(ch), s));
		else
			e.value = s;
		filtered_due.push_back(e);
	endfunction

	function int pending();
		return filtered_due.size();
	endfunction

	task report(string what, int got, int want);
		$display("ERROR %s: got %0d, want %0d", what, got, want);
		errors++;
	endtask

	task check_result(ch_t ch, sample_t f);
		filtered_t e;
		if (filtered_due.size() == 0) begin
			report("result with nothing outstanding, filtered", int'(f), -1);
			return;
		end
		e = filtered_due.pop_front();
		if (ch !== e.ch)
			report("channel_out", int'(ch), int'(e.ch));
		if (f !== e.value)
			report("filtered", int'(f), int'(e.value));
	endtask
endclass

module tb_moving_then_limit_average_filter_unit;
	localparam int IDLE_LIMIT = 1000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	mtla_in_if  samples();
	mtla_out_if results();
	mtla_cfg_if cfg();

	filter_scoreboard sb;

	int  hold_off_left = 0;
	bit  steady = 1'b0;
	int  idle_cycles;
	int  ch_base [CHANNELS];
	ch_t last_ch;

	moving_then_limit_average_filter_unit uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.samples (samples),
		.cfg     (cfg),
		.results (results)
	);

	always #1 clk = ~clk;

	function int pick_gap();
		int r;
		if (steady)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 75)
			return 0;
		if (r < 95)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	task send_sample(ch_t ch, sample_t s);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			samples.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		samples.valid   <= 1'b1;
		samples.channel <= ch;
		samples.sample  <= s;
		do @(posedge clk); while (samples.ready !== 1'b1);
		sb.note_sample(ch, s);
	endtask

	task write_limit(logic [LIMIT_W-1:0] v);
		samples.valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		// Let the pipeline settle fully before touching the register.
		repeat (10) @(posedge clk);
		cfg.valid       <= 1'b1;
		cfg.spike_limit <= v;
		do @(posedge clk); while (cfg.ready !== 1'b1);
		cfg.valid <= 1'b0;
		sb.spike_limit = v;
	endtask

	task random_items(int n);
		int r;
		int span;
		int value;
		for (int i = 0; i < n; i++) begin
			// Mostly runs on one channel, so that back-to-back same-channel
			// transactions are common, with frequent switches between channels.
			if ($urandom_range(0, 9) >= 7)
				last_ch = ch_t'($urandom_range(0, CHANNELS - 1));
			r = $urandom_range(0, 99);
			if (r < 5)
				ch_base[last_ch] = $urandom_range(0, 1) ? 0 : SAMPLE_MAX;
			else if (r < 12)
				ch_base[last_ch] = $urandom_range(0, SAMPLE_MAX);
			if (r < 20) begin
				value = $urandom_range(0, SAMPLE_MAX);
			end else if (r < 40) begin
				value = ch_base[last_ch];
			end else begin
				span = $urandom_range(1, 60);
				value = ch_base[last_ch] + int'($urandom_range(0, 2 * span)) - span;
				if (value < 0)
					value = 0;
				if (value > SAMPLE_MAX)
					value = SAMPLE_MAX;
				if ($urandom_range(0, 3) == 0)
					ch_base[last_ch] = value;
			end
			send_sample(last_ch, sample_t'(value));
		end
	endtask

	// Result side: random stalls, short ones mostly, plus an occasional
	// long hold-off requested from the stimulus thread.
	initial begin
		int stall_left;
		stall_left = 0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (results.valid === 1'b1 && results.ready === 1'b1)
				sb.check_result(results.channel_out, results.filtered);
			if (hold_off_left > 0) begin
				results.ready <= 1'b0;
				hold_off_left--;
			end else if (stall_left > 0) begin
				results.ready <= 1'b0;
				stall_left--;
			end else if (!steady && $urandom_range(0, 5) == 0) begin
				results.ready <= 1'b0;
				stall_left = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 2)
					: $urandom_range(9, 39);
			end else begin
				results.ready <= 1'b1;
			end
		end
	end

	initial begin
		idle_cycles = 0;
		while (idle_cycles < IDLE_LIMIT) begin
			@(posedge clk);
			if ((samples.valid === 1'b1 && samples.ready === 1'b1) ||
			    (results.valid === 1'b1 && results.ready === 1'b1) ||
			    (cfg.valid === 1'b1 && cfg.ready === 1'b1))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		sb = new();
		samples.valid   = 1'b0;
		samples.channel = '0;
		samples.sample  = '0;
		cfg.valid       = 1'b0;
		cfg.spike_limit = '0;
		results.ready   = 1'b0;
		last_ch         = '0;
		for (int c = 0; c < CHANNELS; c++)
			ch_base[c] = $urandom_range(0, SAMPLE_MAX);

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part, under the reset spike limit of 50.
		send_sample(3'd7, 12'd4095);
		send_sample(3'd0, 12'd0);
		send_sample(3'd0, 12'd50);      // jump equal to the limit: accepted
		send_sample(3'd0, 12'd101);     // one above the limit: rejected
		send_sample(3'd0, 12'd4095);
		repeat (6) send_sample(3'd0, 12'd60);
		// Window now full; averaging begins and the average itself spikes.
		repeat (2) send_sample(3'd0, 12'd60);
		send_sample(3'd7, 12'd0);
		send_sample(3'd7, 12'd4095);
		send_sample(3'd3, 12'd2048);
		send_sample(3'd3, 12'd2048);
		send_sample(3'd3, 12'd1998);
		send_sample(3'd3, 12'd1947);
		send_sample(3'd5, 12'd4095);
		send_sample(3'd5, 12'd4045);
		send_sample(3'd5, 12'd4044);

		random_items(190);
		write_limit('0);
		random_items(190);
		write_limit({LIMIT_W{1'b1}});
		random_items(60);
		// Hold the results back long enough for the block to fill and
		// refuse further samples.
		hold_off_left = 100;
		random_items(130);
		write_limit(12'd1);
		steady = 1'b1;
		random_items(190);
		steady = 1'b0;
		write_limit(LIMIT_W'($urandom_range(2, 400)));
		random_items(190);
		write_limit(SPIKE_LIMIT_RST);
		random_items(190);

		samples.valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (16) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule
